>>> design/mtg_pkg.sv
package mtg_pkg;

  // Table geometry and word width
  localparam int unsigned MtN     = 624;
  localparam int unsigned MtM     = 397;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned WordW   = 32;

  // Recurrence and tempering constants of the standard generator
  localparam logic [WordW-1:0] MT_MATRIX    = 32'h9908_b0df;
  localparam logic [WordW-1:0] MT_INIT_MULT = 32'd1812433253;
  localparam logic [WordW-1:0] MT_TEMPER_B  = 32'h9d2c_5680;
  localparam logic [WordW-1:0] MT_TEMPER_C  = 32'hefc6_0000;

  // Last valid table index
  localparam logic [IdxW-1:0] IDX_LAST = IdxW'(MtN - 1);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic draw_rd;    // read the neighbor words of the current position
    logic draw_wr;    // twist the current word, write it back, load the output
    logic seed_start; // load the seed into word 0
    logic seed_mul;   // multiply step of the seeding recurrence
    logic seed_wr;    // add step of the seeding recurrence and table write
  } mtg_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic seed_last;  // the seeding write targets the last table word
  } mtg_sts_t;

  // Output tempering of one table word.
  function automatic logic [WordW-1:0] mtg_temper(input logic [WordW-1:0] w);
    logic [WordW-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & MT_TEMPER_B);
    y = y ^ ((y << 15) & MT_TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Twist of one word: upper bit of the current word, lower bits of the next.
  function automatic logic [WordW-1:0] mtg_twist(input logic [WordW-1:0] cur,
                                                 input logic [WordW-1:0] nxt,
                                                 input logic [WordW-1:0] far);
    logic [WordW-1:0] y;
    logic [WordW-1:0] ya;
    y  = {cur[WordW-1], nxt[WordW-2:0]};
    ya = y >> 1;
    if (y[0]) begin
      ya = ya ^ MT_MATRIX;
    end
    return far ^ ya;
  endfunction

endpackage

>>> design/mersenne_twister_generator.sv
// 32-bit MT19937 generator. An item with in_mode high reseeds the 624-word
// state table from in_seed_value and gives no result; an item with in_mode
// low draws one tempered word. A draw runs as the registered table read of
// the neighbor words, then the twist of the current word, its write-back and
// tempering into the output register; the twist waits while that register is full.
// The table is twisted one word per draw, which yields the same sequence as
// twisting it whole. A reseed holds in_ready low from the accepted item until
// the seeding recurrence has run its multiply step and then its add and table
// write for each of the 623 words after the first. Draws before the first
// reseed return undefined words.
module mersenne_twister_generator
  import mtg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  input  logic [WordW-1:0] in_seed_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] out_random_word
);

  mtg_cmd_t cmd;
  mtg_sts_t sts;

  mtg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtg_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_seed_value   (in_seed_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_random_word (out_random_word)
  );

  // At most one datapath command is issued in any cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.draw_rd, cmd.draw_wr, cmd.seed_start, cmd.seed_mul, cmd.seed_wr}))
    else $error("more than one datapath command at once");

  // A finished twist step always leaves a result in the output register.
  a_wr_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.draw_wr |=> out_valid)
    else $error("draw finished without an output item");

  // After the table read, the twist step follows unless the output is stalled.
  a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.draw_rd |=> (cmd.draw_wr || (out_valid && !out_ready)))
    else $error("table read not followed by the twist step");

  // No item is taken while the table is being seeded.
  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.seed_mul || cmd.seed_wr) |-> !in_ready)
    else $error("input accepted during seeding");

endmodule

>>> design/mtg_ctrl.sv
module mtg_ctrl
  import mtg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_mode,
  output logic      out_valid,
  input  logic      out_ready,
  input  mtg_sts_t  sts,
  output mtg_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_SMUL,
    S_SADD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   calc_go;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  // The twist step may only run when the output register is free.
  assign calc_go = (state_r == S_CALC) && (!out_valid_r || out_ready);

  // Commands for the datapath
  always_comb begin
    cmd            = '0;
    cmd.draw_rd    = accept && !in_mode;
    cmd.seed_start = accept && in_mode;
    cmd.draw_wr    = calc_go;
    cmd.seed_mul   = (state_r == S_SMUL);
    cmd.seed_wr    = (state_r == S_SADD);
  end

  // Next state and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = in_mode ? S_SMUL : S_CALC;
        end
      end
      S_CALC: begin
        if (calc_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SMUL: begin
        state_nxt = S_SADD;
      end
      S_SADD: begin
        state_nxt = sts.seed_last ? S_IDLE : S_SMUL;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/mtg_dp.sv
module mtg_dp
  import mtg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [WordW-1:0] in_seed_value,
  input  mtg_cmd_t         cmd,
  output mtg_sts_t         sts,
  output logic [WordW-1:0] out_random_word
);

  logic [WordW-1:0] mem [MtN];

  logic [IdxW-1:0]  pos_r, pos_nxt;
  logic [IdxW-1:0]  idx_r;
  logic [WordW-1:0] cur_r;
  logic [WordW-1:0] rd_next_r;
  logic [WordW-1:0] rd_far_r;
  logic [WordW-1:0] x_r;
  logic [WordW-1:0] prod_r;
  logic [WordW-1:0] word_r;

  logic [IdxW-1:0]  addr_next;
  logic [IdxW:0]    far_sum;
  logic [IdxW-1:0]  addr_far;
  logic [WordW-1:0] twisted;
  logic [WordW-1:0] seed_word;

  // Neighbor addresses of the current position, wrapping around the table
  assign addr_next = (pos_r == IDX_LAST) ? '0 : pos_r + 1'b1;
  assign far_sum   = {1'b0, pos_r} + (IdxW+1)'(MtM);
  assign addr_far  = (far_sum >= (IdxW+1)'(MtN)) ? IdxW'(far_sum - (IdxW+1)'(MtN))
                                                 : far_sum[IdxW-1:0];
  assign pos_nxt   = addr_next;

  // Twist of the word at the current position, done just before it is used
  assign twisted   = mtg_twist(cur_r, rd_next_r, rd_far_r);

  // Add step of the seeding recurrence
  assign seed_word = prod_r + WordW'(idx_r);

  assign sts.seed_last   = (idx_r == IDX_LAST);
  assign out_random_word = word_r;

  // Table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.seed_start) begin
      mem[0] <= in_seed_value;
    end else if (cmd.seed_wr) begin
      mem[idx_r] <= seed_word;
    end else if (cmd.draw_wr) begin
      mem[pos_r] <= twisted;
    end
    if (cmd.draw_rd) begin
      rd_next_r <= mem[addr_next];
      rd_far_r  <= mem[addr_far];
    end
  end

  // Read position; a reseed restarts at word 0 with a twist pending
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.seed_start) begin
      pos_r <= '0;
    end else if (cmd.draw_wr) begin
      pos_r <= pos_nxt;
    end
  end

  // Untwisted copy of the word at the current position, and the output word
  always_ff @(posedge clk) begin
    if (cmd.seed_start) begin
      cur_r <= in_seed_value;
    end else if (cmd.draw_wr) begin
      cur_r  <= rd_next_r;
      word_r <= mtg_temper(twisted);
    end
  end

  // Seeding recurrence: multiply, then add and write in the next cycle
  always_ff @(posedge clk) begin
    if (cmd.seed_start) begin
      x_r   <= in_seed_value;
      idx_r <= IdxW'(1);
    end else if (cmd.seed_mul) begin
      prod_r <= MT_INIT_MULT * (x_r ^ (x_r >> 30));
    end else if (cmd.seed_wr) begin
      x_r   <= seed_word;
      idx_r <= idx_r + 1'b1;
    end
  end

endmodule
